// File: rtl/shpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shpg_pkg
// Types, constants and digit permutations for the scrambled Halton point
// generator (bases 5 and 3).
// ----------------------------------------------------------------------------
package shpg_pkg;

  // Input item: draw a point or load a dimension counter
  typedef struct packed {
    logic        kind;
    logic [2:0]  dim;
    logic [31:0] load_value;
  } shpg_in_t;

  // Result item: one 2D point in unsigned Q0.32
  typedef struct packed {
    logic [31:0] x_frac;
    logic [31:0] y_frac;
    logic        point_valid;
  } shpg_out_t;

  // Item kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Edge margin register
  localparam int          MARGIN_W     = 30;
  localparam logic [29:0] MARGIN_RESET = 30'd429497;

  // Counter advance after each draw
  localparam logic [31:0] COUNTER_STEP = 32'd7;

  // Reciprocals for exact 32-bit division by 3 and 5: q = (v * RECIP) >> SHIFT
  localparam logic [31:0] RECIP3 = 32'd2863311531;
  localparam logic [31:0] RECIP5 = 32'd3435973837;
  localparam int          SHIFT3 = 33;
  localparam int          SHIFT5 = 34;

  // Base-5 digit scramble: 0->1, 1->3, 2->4, 3->0, 4->2
  function automatic logic [2:0] perm5(input logic [2:0] d);
    logic [2:0] p;
    case (d)
      3'd0:    p = 3'd1;
      3'd1:    p = 3'd3;
      3'd2:    p = 3'd4;
      3'd3:    p = 3'd0;
      3'd4:    p = 3'd2;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // Base-3 digit scramble: 0->1, 1->0, 2->2
  function automatic logic [1:0] perm3(input logic [1:0] d);
    logic [1:0] p;
    case (d)
      2'd0:    p = 2'd1;
      2'd1:    p = 2'd0;
      2'd2:    p = 2'd2;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/scrambled_halton_point_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrambled_halton_point_generator
// Per-dimension counters; a draw returns the scrambled base-5 / base-3
// radical inverse of the counter as a Q0.32 point and advances the counter.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data  (shpg_in_t)
//   out      output     out_valid/ out_stall out_data (shpg_out_t)
//   cfg      input      cfg_wr_en            cfg_wr_data (edge margin)
//
// A load leaves the sequencer idle, so the input is not stalled. A draw with
// a dimension in range works through the digits of the counter (at most 14
// in base 5 and 21 in base 3) on one shared 32x32 multiplier used for the
// digit steps and the margin product, then runs a 32-step restoring divider
// once per base; the input stays stalled until the point is finished. A draw
// with a dimension out of range skips the arithmetic. The result sits in
// an output register, so the next item is accepted while it waits on
// out_stall; a finished point that finds that register still stalled holds
// the sequencer until the register frees up. Reset is synchronous, clears
// the counters and restores the default margin.
// ----------------------------------------------------------------------------
module scrambled_halton_point_generator #(
  parameter int NUM_DIMS = 6
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  shpg_pkg::shpg_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output shpg_pkg::shpg_out_t  out_data,
  input  wire                  cfg_wr_en,
  input  wire [29:0]           cfg_wr_data
);
  import shpg_pkg::*;

  localparam int IDX_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DMUL  = 4'd1;
  localparam logic [3:0] S_DSTEP = 4'd2;
  localparam logic [3:0] S_PLO   = 4'd3;
  localparam logic [3:0] S_PHI   = 4'd4;
  localparam logic [3:0] S_PACC  = 4'd5;
  localparam logic [3:0] S_PSUB  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]          state_r,   state_nxt;
  logic [29:0]         eps_r,     eps_nxt;
  logic [31:0]         ctr_r      [NUM_DIMS];
  logic [31:0]         ctr_nxt    [NUM_DIMS];
  logic [31:0]         v_r,       v_nxt;
  logic [31:0]         save_r,    save_nxt;
  logic                base5_r,   base5_nxt;
  logic [33:0]         r_r,       r_nxt;
  logic [33:0]         den_r,     den_nxt;
  logic [63:0]         mul_r,     mul_nxt;
  logic [63:0]         acc_r,     acc_nxt;
  logic [33:0]         rem_r,     rem_nxt;
  logic [31:0]         shq_r,     shq_nxt;
  logic [4:0]          bit_r,     bit_nxt;
  logic [31:0]         x_r,       x_nxt;
  logic [31:0]         y_r,       y_nxt;
  logic                pv_r,      pv_nxt;
  logic                out_valid_r, out_valid_nxt;
  shpg_out_t           out_data_r,  out_data_nxt;

  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic                in_fire;
  logic                dim_ok;
  logic [IDX_W-1:0]    dim_idx;
  logic [31:0]         q;
  logic [31:0]         qb;
  logic [31:0]         dig;
  logic [2:0]          pdig;
  logic [65:0]         scaled;
  logic [34:0]         trial;
  logic [35:0]         diff;
  logic                ge;
  logic [31:0]         res;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && (state_r == S_IDLE);
  assign dim_ok    = ({1'b0, in_data.dim} < 4'(NUM_DIMS));
  assign dim_idx   = in_data.dim[IDX_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_DMUL: begin
        mul_a = v_r;
        mul_b = base5_r ? RECIP5 : RECIP3;
      end
      S_PLO: begin
        mul_a = {15'd0, r_r[16:0]};
        mul_b = {2'd0, eps_r};
      end
      S_PHI: begin
        mul_a = {15'd0, r_r[33:17]};
        mul_b = {2'd0, eps_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    mul_nxt = 64'(mul_a) * 64'(mul_b);
  end

  // Digit step: quotient, remainder digit and its scramble
  always_comb begin
    if (base5_r) begin
      q  = {2'd0, mul_r[63:SHIFT5]};
      qb = q + {q[29:0], 2'd0};
    end else begin
      q  = {1'd0, mul_r[63:SHIFT3]};
      qb = q + {q[30:0], 1'd0};
    end
    dig  = v_r - qb;
    pdig = base5_r ? perm5(dig[2:0]) : {1'b0, perm3(dig[1:0])};
  end

  // Scaled numerator r * (2^32 - 2*eps) and one divider step
  assign scaled = {r_r, 32'd0} - {1'b0, acc_r, 1'b0};
  assign trial  = {rem_r, shq_r[31]};
  assign diff   = {1'b0, trial} - {2'd0, den_r};
  assign ge     = !diff[35];
  assign res    = shq_r + {2'd0, eps_r};

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    eps_nxt       = eps_r;
    ctr_nxt       = ctr_r;
    v_nxt         = v_r;
    save_nxt      = save_r;
    base5_nxt     = base5_r;
    r_nxt         = r_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    shq_nxt       = shq_r;
    bit_nxt       = bit_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pv_nxt        = pv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      eps_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_LOAD) begin
            if (dim_ok) begin
              ctr_nxt[dim_idx] = in_data.load_value;
            end
          end else if (dim_ok) begin
            ctr_nxt[dim_idx] = ctr_r[dim_idx] + COUNTER_STEP;
            v_nxt            = ctr_r[dim_idx];
            save_nxt         = ctr_r[dim_idx];
            base5_nxt        = 1'b1;
            r_nxt            = 34'd0;
            den_nxt          = 34'd1;
            state_nxt        = S_DMUL;
          end else begin
            x_nxt     = 32'd0;
            y_nxt     = 32'd0;
            pv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end
      // Issue the reciprocal multiply, or finish the digit string
      S_DMUL: begin
        state_nxt = (v_r == 32'd0) ? S_PLO : S_DSTEP;
      end
      // Fold one scrambled digit into numerator and denominator
      S_DSTEP: begin
        if (base5_r) begin
          r_nxt   = r_r + {r_r[31:0], 2'd0} + {31'd0, pdig};
          den_nxt = den_r + {den_r[31:0], 2'd0};
        end else begin
          r_nxt   = r_r + {r_r[32:0], 1'd0} + {31'd0, pdig};
          den_nxt = den_r + {den_r[32:0], 1'd0};
        end
        v_nxt     = q;
        state_nxt = S_DMUL;
      end
      S_PLO: begin
        state_nxt = S_PHI;
      end
      S_PHI: begin
        acc_nxt   = mul_r;
        state_nxt = S_PACC;
      end
      S_PACC: begin
        acc_nxt   = acc_r + {mul_r[46:0], 17'd0};
        state_nxt = S_PSUB;
      end
      // Load the divider with the scaled numerator
      S_PSUB: begin
        rem_nxt   = scaled[65:32];
        shq_nxt   = scaled[31:0];
        bit_nxt   = 5'd31;
        state_nxt = S_DIV;
      end
      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        rem_nxt = ge ? diff[33:0] : trial[33:0];
        shq_nxt = {shq_r[30:0], ge};
        if (bit_r == 5'd0) begin
          state_nxt = S_RES;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      // Store one coordinate; rerun for base 3 after base 5
      S_RES: begin
        if (base5_r) begin
          x_nxt     = res;
          base5_nxt = 1'b0;
          v_nxt     = save_r;
          r_nxt     = 34'd0;
          den_nxt   = 34'd1;
          state_nxt = S_DMUL;
        end else begin
          y_nxt     = res;
          pv_nxt    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load a finished point, drop a transferred one
    if (state_r == S_FIN && (!out_valid_r || !out_stall)) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.x_frac      = x_r;
      out_data_nxt.y_frac      = y_r;
      out_data_nxt.point_valid = pv_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eps_r       <= MARGIN_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DIMS; i++) begin
        ctr_r[i] <= 32'd0;
      end
    end else begin
      state_r     <= state_nxt;
      eps_r       <= eps_nxt;
      out_valid_r <= out_valid_nxt;
      ctr_r       <= ctr_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    save_r     <= save_nxt;
    base5_r    <= base5_nxt;
    r_r        <= r_nxt;
    den_r      <= den_nxt;
    mul_r      <= mul_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    shq_r      <= shq_nxt;
    bit_r      <= bit_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    pv_r       <= pv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/shpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shpg_checker
// Port-level checks for the scrambled Halton point generator.
// ----------------------------------------------------------------------------
module shpg_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input shpg_pkg::shpg_in_t   in_data,
  input wire                  out_valid,
  input wire                  out_stall,
  input shpg_pkg::shpg_out_t  out_data
);
  import shpg_pkg::*;

  // A draw keeps the input stalled on the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.kind == KIND_DRAW) |=> in_stall)
    else $error("draw transfer not followed by stall");

  // A load leaves the input free on the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.kind == KIND_LOAD) |=> !in_stall)
    else $error("load transfer left the input stalled");

  // An invalid point carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.point_valid) |->
      (out_data.x_frac == 32'd0 && out_data.y_frac == 32'd0))
    else $error("invalid point with nonzero coordinates");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind scrambled_halton_point_generator shpg_checker u_shpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: test/scrambled_halton_point_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrambled_halton_point_generator_tb
// Drives loads and draws, some directed and most random, through the block
// under several edge margins, with random gaps and stalls on both channels.
// Each point is compared field by field against an in-bench prediction of
// the scrambled base-5 / base-3 radical inverse.
// ----------------------------------------------------------------------------
module scrambled_halton_point_generator_tb;
  import shpg_pkg::*;

  localparam int          NUM_DIMS_TB     = 6;
  localparam int unsigned BASE_X          = 5;
  localparam int unsigned BASE_Y          = 3;
  localparam int unsigned DRAIN_CYCLES    = 160;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned HOLD_OFF_AFTER  = 200;
  localparam int unsigned PHASE_ITEMS     = 330;
  localparam int unsigned PHASE_COUNT     = 5;
  localparam int unsigned CYCLE_LIMIT     = 2000000;

  // Counter and margin tracking plus the queue of points still owed
  class point_scoreboard;
    logic [31:0] dim_count [NUM_DIMS_TB];
    logic [29:0] margin;
    shpg_out_t   expected_points [$];
    int unsigned error_count;
    int unsigned checked_count;

    function new();
      foreach (dim_count[i]) dim_count[i] = '0;
      margin        = MARGIN_RESET;
      error_count   = 0;
      checked_count = 0;
    endfunction

    function void set_margin(input logic [29:0] value);
      margin = value;
    endfunction

    function int unsigned scramble_digit(input int unsigned base, input int unsigned digit);
      int unsigned mapped;
      if (base == BASE_X) begin
        case (digit)
          0:       mapped = 1;
          1:       mapped = 3;
          2:       mapped = 4;
          3:       mapped = 0;
          default: mapped = 2;
        endcase
      end else begin
        case (digit)
          0:       mapped = 1;
          1:       mapped = 0;
          default: mapped = 2;
        endcase
      end
      return mapped;
    endfunction

    // Reverse the digits of n, scramble them, and scale into the margin band
    function logic [31:0] radical_inverse(input logic [31:0] n, input int unsigned base);
      logic [63:0]  rest;
      logic [63:0]  digits;
      logic [63:0]  denom;
      logic [32:0]  span;
      logic [127:0] scaled;
      rest   = 64'(n);
      digits = '0;
      denom  = 64'd1;
      span   = 33'h1_0000_0000 - 33'({margin, 1'b0});
      while (rest != 0) begin
        digits = digits * 64'(base)
                 + 64'(scramble_digit(base, 32'(rest % 64'(base))));
        denom  = denom * 64'(base);
        rest   = rest / 64'(base);
      end
      scaled = (128'(digits) * 128'(span)) / 128'(denom);
      return 32'(128'(margin) + scaled);
    endfunction

    function void note_item(input shpg_in_t item);
      shpg_out_t point;
      if (item.kind == KIND_LOAD) begin
        if (item.dim < NUM_DIMS_TB) dim_count[item.dim] = item.load_value;
      end else if (item.dim >= NUM_DIMS_TB) begin
        point = '0;
        expected_points.push_back(point);
      end else begin
        point.x_frac      = radical_inverse(dim_count[item.dim], BASE_X);
        point.y_frac      = radical_inverse(dim_count[item.dim], BASE_Y);
        point.point_valid = 1'b1;
        dim_count[item.dim] = dim_count[item.dim] + COUNTER_STEP;
        expected_points.push_back(point);
      end
    endfunction

    function void check_point(input shpg_out_t got);
      shpg_out_t want;
      checked_count++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h valid=%b", $time,
                 got.x_frac, got.y_frac, got.point_valid);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.x_frac !== want.x_frac) begin
          $display("%0t: x_frac expected %h actual %h", $time, want.x_frac, got.x_frac);
          error_count++;
        end
        if (got.y_frac !== want.y_frac) begin
          $display("%0t: y_frac expected %h actual %h", $time, want.y_frac, got.y_frac);
          error_count++;
        end
        if (got.point_valid !== want.point_valid) begin
          $display("%0t: point_valid expected %b actual %b", $time,
                   want.point_valid, got.point_valid);
          error_count++;
        end
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  shpg_in_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  shpg_out_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [29:0] cfg_wr_data = '0;

  point_scoreboard board = new();
  bit              calm_sender = 1'b0;

  scrambled_halton_point_generator #(
    .NUM_DIMS(NUM_DIMS_TB)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic shpg_in_t make_item(input logic kind, input int unsigned dim,
                                         input logic [31:0] value);
    shpg_in_t item;
    item.kind       = kind;
    item.dim        = 3'(dim);
    item.load_value = value;
    return item;
  endfunction

  // Draws dominate; loads mix small, near-wrap and full-width counter values
  function automatic shpg_in_t random_item();
    logic [31:0] value;
    int unsigned dim;
    value = $urandom;
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 99) < 8) dim = $urandom_range(NUM_DIMS_TB, 7);
      else dim = $urandom_range(0, NUM_DIMS_TB - 1);
      return make_item(KIND_DRAW, dim, value);
    end
    case ($urandom_range(0, 3))
      0:       value = $urandom_range(0, 300);
      1:       value = 32'hFFFF_FFFF - $urandom_range(0, 40);
      2:       value = value >> $urandom_range(0, 31);
      default: value = $urandom;
    endcase
    return make_item(KIND_LOAD, $urandom_range(0, 7), value);
  endfunction

  // Offer one item, hold it until the transfer, then idle for the gap
  task automatic send_item(input shpg_in_t item);
    int unsigned gap;
    gap = calm_sender ? 0 : gap_length();
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    board.note_item(item);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait out every owed point and any load still in flight
  task automatic drain_block();
    in_valid <= 1'b0;
    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_margin(input logic [29:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_margin(value);
  endtask

  // Stimulus: reset, directed corners, then random phases per margin
  initial begin : stimulus
    logic [29:0] margins [PHASE_COUNT];
    margins[0] = 30'd0;
    margins[1] = 30'h3FFF_FFFF;
    margins[2] = 30'd1;
    margins[3] = 30'($urandom_range(0, 32'h3FFF_FFFF));
    margins[4] = MARGIN_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero counters, out-of-range draws and ignored out-of-range loads
    send_item(make_item(KIND_DRAW, 0, 32'h0));
    send_item(make_item(KIND_DRAW, NUM_DIMS_TB - 1, 32'hFFFF_FFFF));
    send_item(make_item(KIND_DRAW, 6, 32'h0));
    send_item(make_item(KIND_DRAW, 7, 32'hFFFF_FFFF));
    send_item(make_item(KIND_LOAD, 6, 32'h1234_5678));
    send_item(make_item(KIND_LOAD, 7, 32'hFFFF_FFFF));
    send_item(make_item(KIND_DRAW, 6, 32'h0));
    // Counter wrap past the top of the 32-bit range
    send_item(make_item(KIND_LOAD, 1, 32'hFFFF_FFFF));
    send_item(make_item(KIND_DRAW, 1, 32'h0));
    send_item(make_item(KIND_DRAW, 1, 32'h0));
    send_item(make_item(KIND_LOAD, 2, 32'hFFFF_FFFA));
    send_item(make_item(KIND_DRAW, 2, 32'h0));
    send_item(make_item(KIND_DRAW, 2, 32'h0));
    // Longest digit strings in each base
    send_item(make_item(KIND_LOAD, 3, 32'd1220703125));
    send_item(make_item(KIND_DRAW, 3, 32'h0));
    send_item(make_item(KIND_LOAD, 4, 32'd3486784401));
    send_item(make_item(KIND_DRAW, 4, 32'h0));
    // Reload to zero and alternating bit patterns
    send_item(make_item(KIND_DRAW, 0, 32'h0));
    send_item(make_item(KIND_LOAD, 0, 32'h0));
    send_item(make_item(KIND_DRAW, 0, 32'h0));
    send_item(make_item(KIND_LOAD, 5, 32'h5555_5555));
    send_item(make_item(KIND_DRAW, 5, 32'h0));
    send_item(make_item(KIND_LOAD, 5, 32'hAAAA_AAAA));
    send_item(make_item(KIND_DRAW, 5, 32'h0));

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_block();
      write_margin(margins[phase]);
      calm_sender = (phase == 2);
      send_item(make_item(KIND_LOAD, 0, 32'h0));
      send_item(make_item(KIND_DRAW, 0, 32'h0));
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end

    drain_block();
    if (board.error_count == 0) begin
      $display("scrambled_halton_point_generator: match");
    end else begin
      $display("scrambled_halton_point_generator: mismatch");
    end
    $finish;
  end

  // Result side stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    int unsigned stall_run;
    int unsigned open_run;
    bit          hold_done;
    stall_run = 0;
    open_run  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && board.checked_count >= HOLD_OFF_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (stall_run == 0 && open_run == 0) begin
          stall_run = gap_length();
          if ($urandom_range(0, 99) < 10) open_run = $urandom_range(100, 300);
          else open_run = $urandom_range(1, 12);
        end
        if (stall_run != 0) begin
          out_stall <= 1'b1;
          stall_run--;
        end else begin
          out_stall <= 1'b0;
          open_run--;
        end
      end
    end
  end

  // Check each point the cycle before its transfer edge, while it is stable
  initial begin : result_monitor
    forever begin
      @(negedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) board.check_point(out_data);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("scrambled_halton_point_generator: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/shpg_pkg.sv
rtl/scrambled_halton_point_generator.sv
rtl/shpg_checker.sv
test/scrambled_halton_point_generator_tb.sv
